// ===== hdl/stxetx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stxetx_pkg
// Shared types and constants of the start/end marker frame extractor.
// ----------------------------------------------------------------------------
package stxetx_pkg;

  localparam int BYTE_W    = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER   = 1'd1;

  localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'h02;
  localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'h03;

  typedef enum logic [1:0] {
    CMD_DATA  = 2'd0,
    CMD_EMPTY = 2'd1,
    CMD_OVF   = 2'd2
  } cmd_kind_t;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'b01,
    BK_DRAIN = 2'b10
  } bk_state_t;

endpackage

// ===== hdl/stxetx_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stxetx_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module stxetx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/stxetx_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stxetx_queue
// Two-entry command queue between the byte classifier and the drain engine.
// ----------------------------------------------------------------------------
module stxetx_queue #(
  parameter int DW = 9
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  input  logic          pop,
  output logic [DW-1:0] head_data,
  output logic          head_valid,
  output logic          full
);

  logic [DW-1:0] ent_r [2];
  logic          wp_r, wp_nxt;
  logic          rp_r, rp_nxt;
  logic [1:0]    cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = ~wp_r;
    end
    if (pop) begin
      rp_nxt = ~rp_r;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      ent_r[wp_r] <= push_data;
    end
  end

  assign head_data  = ent_r[rp_r];
  assign head_valid = (cnt_r != 2'd0);
  assign full       = cnt_r[1];

endmodule

// ===== hdl/stxetx_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stxetx_front
// Input side: marker registers, frame tracking, payload writes and commands.
// ----------------------------------------------------------------------------
module stxetx_front #(
  parameter int FRAME_DEPTH = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  input  logic [stxetx_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [stxetx_pkg::BYTE_W-1:0]      cfg_data,
  input  logic                               in_accept,
  input  logic [stxetx_pkg::BYTE_W-1:0]      rx_byte,
  output logic                               ram_we,
  output logic [$clog2(FRAME_DEPTH)-1:0]     ram_waddr,
  output logic                               cmd_push,
  output stxetx_pkg::cmd_kind_t              cmd_kind,
  output logic [$clog2(FRAME_DEPTH+1)-1:0]   cmd_count
);

  import stxetx_pkg::*;

  localparam int AW = $clog2(FRAME_DEPTH);
  localparam int CW = $clog2(FRAME_DEPTH + 1);

  logic [BYTE_W-1:0] start_r, start_nxt;
  logic [BYTE_W-1:0] end_r, end_nxt;
  logic              inside_r, inside_nxt;
  logic              ovf_r, ovf_nxt;
  logic [CW-1:0]     count_r, count_nxt;

  always_comb begin
    start_nxt = start_r;
    end_nxt   = end_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_START_MARKER: start_nxt = cfg_data;
        CFG_END_MARKER:   end_nxt   = cfg_data;
        default:          start_nxt = start_r;
      endcase
    end
  end

  always_comb begin
    inside_nxt = inside_r;
    ovf_nxt    = ovf_r;
    count_nxt  = count_r;
    ram_we     = 1'b0;
    cmd_push   = 1'b0;
    cmd_kind   = CMD_DATA;
    if (ovf_r) begin
      cmd_kind = CMD_OVF;
    end else if (count_r == '0) begin
      cmd_kind = CMD_EMPTY;
    end
    if (in_accept) begin
      if (!inside_r) begin
        if (rx_byte == start_r) begin
          inside_nxt = 1'b1;
          ovf_nxt    = 1'b0;
          count_nxt  = '0;
        end
      end else if (rx_byte == end_r) begin
        cmd_push   = 1'b1;
        inside_nxt = 1'b0;
        ovf_nxt    = 1'b0;
        count_nxt  = '0;
      end else if (rx_byte == start_r) begin
        ovf_nxt   = 1'b0;
        count_nxt = '0;
      end else if (!ovf_r) begin
        if (count_r < CW'(FRAME_DEPTH)) begin
          ram_we    = 1'b1;
          count_nxt = count_r + CW'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r  <= START_MARKER_RST;
      end_r    <= END_MARKER_RST;
      inside_r <= 1'b0;
      ovf_r    <= 1'b0;
      count_r  <= '0;
    end else begin
      start_r  <= start_nxt;
      end_r    <= end_nxt;
      inside_r <= inside_nxt;
      ovf_r    <= ovf_nxt;
      count_r  <= count_nxt;
    end
  end

  assign ram_waddr = count_r[AW-1:0];
  assign cmd_count = count_r;

endmodule

// ===== hdl/stxetx_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stxetx_back
// Output side: pops frame commands, reads the payload RAM, drives results.
// ----------------------------------------------------------------------------
module stxetx_back #(
  parameter int FRAME_DEPTH = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_valid,
  input  stxetx_pkg::cmd_kind_t              q_kind,
  input  logic [$clog2(FRAME_DEPTH+1)-1:0]   q_count,
  output logic                               q_pop,
  output logic                               ram_re,
  output logic [$clog2(FRAME_DEPTH)-1:0]     ram_raddr,
  input  logic [stxetx_pkg::BYTE_W-1:0]      ram_rdata,
  output logic                               drain_done,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [stxetx_pkg::BYTE_W-1:0]      out_payload_byte,
  output logic                               out_frame_last,
  output logic                               out_frame_empty,
  output logic                               out_frame_overflow
);

  import stxetx_pkg::*;

  localparam int AW = $clog2(FRAME_DEPTH);
  localparam int CW = $clog2(FRAME_DEPTH + 1);

  bk_state_t         state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     iss_r, iss_nxt;
  logic              pend_r, pend_nxt;
  logic              pend_last_r, pend_last_nxt;
  logic              ov_r, ov_nxt;
  logic [BYTE_W-1:0] ob_r, ob_nxt;
  logic              ol_r, ol_nxt;
  logic              oe_r, oe_nxt;
  logic              oo_r, oo_nxt;
  logic              slot_free;
  logic              load_data;
  logic              issue;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    iss_nxt       = iss_r;
    pend_nxt      = pend_r;
    pend_last_nxt = pend_last_r;
    ov_nxt        = ov_r;
    ob_nxt        = ob_r;
    ol_nxt        = ol_r;
    oe_nxt        = oe_r;
    oo_nxt        = oo_r;
    q_pop         = 1'b0;
    drain_done    = 1'b0;
    slot_free     = !ov_r || !out_stall;
    load_data     = 1'b0;
    issue         = 1'b0;

    if (!out_stall) begin
      ov_nxt = 1'b0;
    end

    case (state_r)
      BK_IDLE: begin
        if (q_valid && q_kind == CMD_DATA) begin
          q_pop     = 1'b1;
          cnt_nxt   = q_count;
          iss_nxt   = '0;
          state_nxt = BK_DRAIN;
        end else if (q_valid && slot_free) begin
          q_pop  = 1'b1;
          ov_nxt = 1'b1;
          ob_nxt = '0;
          ol_nxt = 1'b1;
          oe_nxt = (q_kind == CMD_EMPTY);
          oo_nxt = (q_kind == CMD_OVF);
        end
      end
      BK_DRAIN: begin
        load_data = pend_r && slot_free;
        issue     = (iss_r < cnt_r) && (!pend_r || load_data);
        if (load_data) begin
          ov_nxt = 1'b1;
          ob_nxt = ram_rdata;
          ol_nxt = pend_last_r;
          oe_nxt = 1'b0;
          oo_nxt = 1'b0;
          if (pend_last_r) begin
            drain_done = 1'b1;
            state_nxt  = BK_IDLE;
          end
        end
        if (issue) begin
          iss_nxt       = iss_r + CW'(1);
          pend_last_nxt = (iss_r + CW'(1) == cnt_r);
          pend_nxt      = 1'b1;
        end else if (load_data) begin
          pend_nxt = 1'b0;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      pend_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      ov_r    <= ov_nxt;
    end
    cnt_r       <= cnt_nxt;
    iss_r       <= iss_nxt;
    pend_last_r <= pend_last_nxt;
    ob_r        <= ob_nxt;
    ol_r        <= ol_nxt;
    oe_r        <= oe_nxt;
    oo_r        <= oo_nxt;
  end

  assign ram_re             = issue;
  assign ram_raddr          = iss_r[AW-1:0];
  assign out_valid          = ov_r;
  assign out_payload_byte   = ob_r;
  assign out_frame_last     = ol_r;
  assign out_frame_empty    = oe_r;
  assign out_frame_overflow = oo_r;

endmodule

// ===== hdl/stx_etx_frame_extractor_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stx_etx_frame_extractor_core
// Start/end marker deframer with a buffered payload and a drain engine.
// ----------------------------------------------------------------------------
// One received byte is taken per cycle while input is not stalled. Payload
// bytes go into a FRAME_DEPTH byte RAM; the end marker queues a frame
// command (two entries deep) for the drain engine, which reads the RAM
// through its registered read port and gives one result word per cycle
// while the output is not stalled. The payload RAM holds a single frame, and
// that sets the pace across frames: while a frame with payload is queued or
// draining, input is stalled. Empty and overflow frames give one result each
// and stall input only when the command queue is full. Configuration writes
// are always ready; the marker registers reset to 0x02 (start) and 0x03 (end).
// ----------------------------------------------------------------------------
module stx_etx_frame_extractor_core #(
  parameter int FRAME_DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [stxetx_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [stxetx_pkg::BYTE_W-1:0]     cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [stxetx_pkg::BYTE_W-1:0]     in_rx_byte,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [stxetx_pkg::BYTE_W-1:0]     out_payload_byte,
  output logic                              out_frame_last,
  output logic                              out_frame_empty,
  output logic                              out_frame_overflow
);

  import stxetx_pkg::*;

  localparam int AW = $clog2(FRAME_DEPTH);
  localparam int CW = $clog2(FRAME_DEPTH + 1);
  localparam int QW = CW + 2;

  logic              in_accept;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;
  logic              cmd_push;
  cmd_kind_t         cmd_kind;
  logic [CW-1:0]     cmd_count;
  logic [QW-1:0]     q_head;
  logic              q_valid;
  logic              q_full;
  logic              q_pop;
  logic              drain_done;
  logic              busy_r, busy_nxt;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full || busy_r;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    busy_nxt = busy_r;
    if (cmd_push && cmd_kind == CMD_DATA) begin
      busy_nxt = 1'b1;
    end else if (drain_done) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  stxetx_front #(
    .FRAME_DEPTH(FRAME_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_accept (in_accept),
    .rx_byte   (in_rx_byte),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .cmd_push  (cmd_push),
    .cmd_kind  (cmd_kind),
    .cmd_count (cmd_count)
  );

  stxetx_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(FRAME_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_rx_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  stxetx_queue #(
    .DW(QW)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (cmd_push),
    .push_data  ({cmd_kind, cmd_count}),
    .pop        (q_pop),
    .head_data  (q_head),
    .head_valid (q_valid),
    .full       (q_full)
  );

  stxetx_back #(
    .FRAME_DEPTH(FRAME_DEPTH)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_kind             (cmd_kind_t'(q_head[QW-1:CW])),
    .q_count            (q_head[CW-1:0]),
    .q_pop              (q_pop),
    .ram_re             (ram_re),
    .ram_raddr          (ram_raddr),
    .ram_rdata          (ram_rdata),
    .drain_done         (drain_done),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_payload_byte   (out_payload_byte),
    .out_frame_last     (out_frame_last),
    .out_frame_empty    (out_frame_empty),
    .out_frame_overflow (out_frame_overflow)
  );

endmodule

// ===== sim/stx_etx_frame_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stx_etx_frame_monitor
// Watches the marker, byte and result channels of the frame extractor, keeps
// its own deframing state and compares every result word against the words
// that the accepted bytes call for, oldest first.
// ----------------------------------------------------------------------------
module stx_etx_frame_monitor #(
  parameter int FRAME_DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [stxetx_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [stxetx_pkg::BYTE_W-1:0]     cfg_data,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [stxetx_pkg::BYTE_W-1:0]     in_rx_byte,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [stxetx_pkg::BYTE_W-1:0]     out_payload_byte,
  input  logic                              out_frame_last,
  input  logic                              out_frame_empty,
  input  logic                              out_frame_overflow,
  output int                                fail_count,
  output int                                words_due
);
  import stxetx_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              empty;
    logic              ovf;
  } frame_word_t;

  frame_word_t       payload_words_q[$];
  logic [BYTE_W-1:0] frame_buf [FRAME_DEPTH];
  int unsigned       buf_count = 0;
  logic              in_frame = 1'b0;
  logic              ovf_seen = 1'b0;
  logic [BYTE_W-1:0] stx_value = START_MARKER_RST;
  logic [BYTE_W-1:0] etx_value = END_MARKER_RST;
  int                errors = 0;

  initial begin
    fail_count = 0;
    words_due  = 0;
  end

  task automatic push_word(input logic [BYTE_W-1:0] data, input logic last,
                           input logic empty, input logic ovf);
    frame_word_t w;
    w.data  = data;
    w.last  = last;
    w.empty = empty;
    w.ovf   = ovf;
    payload_words_q.push_back(w);
  endtask

  task automatic deframe_byte(input logic [BYTE_W-1:0] b);
    cmd_kind_t   kind;
    int unsigned i;
    if (!in_frame) begin
      if (b == stx_value) begin
        in_frame  = 1'b1;
        buf_count = 0;
        ovf_seen  = 1'b0;
      end
    end else if (b == etx_value) begin
      if (ovf_seen) begin
        kind = CMD_OVF;
      end else if (buf_count == 0) begin
        kind = CMD_EMPTY;
      end else begin
        kind = CMD_DATA;
      end
      case (kind)
        CMD_OVF: begin
          push_word('0, 1'b1, 1'b0, 1'b1);
        end
        CMD_EMPTY: begin
          push_word('0, 1'b1, 1'b1, 1'b0);
        end
        default: begin
          for (i = 0; i < buf_count; i++) begin
            push_word(frame_buf[i], (i + 1 == buf_count), 1'b0, 1'b0);
          end
        end
      endcase
      in_frame  = 1'b0;
      buf_count = 0;
      ovf_seen  = 1'b0;
    end else if (b == stx_value) begin
      buf_count = 0;
      ovf_seen  = 1'b0;
    end else if (!ovf_seen) begin
      if (buf_count < FRAME_DEPTH) begin
        frame_buf[buf_count] = b;
        buf_count++;
      end else begin
        ovf_seen = 1'b1;
      end
    end
  endtask

  task automatic check_word();
    frame_word_t got;
    frame_word_t want;
    got.data  = out_payload_byte;
    got.last  = out_frame_last;
    got.empty = out_frame_empty;
    got.ovf   = out_frame_overflow;
    if (payload_words_q.size() == 0) begin
      if (errors < 10) begin
        $display("unexpected word: byte %02h last %0b empty %0b ovf %0b",
                 got.data, got.last, got.empty, got.ovf);
      end
      errors++;
    end else begin
      want = payload_words_q.pop_front();
      if (got.data !== want.data || got.last !== want.last ||
          got.empty !== want.empty || got.ovf !== want.ovf) begin
        if (errors < 10) begin
          $display("word mismatch: expected byte %02h last %0b empty %0b ovf %0b",
                   want.data, want.last, want.empty, want.ovf);
          $display("               actual   byte %02h last %0b empty %0b ovf %0b",
                   got.data, got.last, got.empty, got.ovf);
        end
        errors++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      stx_value = START_MARKER_RST;
      etx_value = END_MARKER_RST;
      in_frame  = 1'b0;
      buf_count = 0;
      ovf_seen  = 1'b0;
      payload_words_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        check_word();
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_START_MARKER: stx_value = cfg_data;
          CFG_END_MARKER:   etx_value = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        deframe_byte(in_rx_byte);
      end
    end
    words_due  <= payload_words_q.size();
    fail_count <= errors;
  end

endmodule

// ===== sim/stx_etx_frame_extractor_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stx_etx_frame_extractor_core_tb
// Drives byte streams through the frame extractor under several marker
// settings: a directed opening, then mostly well-formed frames of random
// length and content mixed with line noise and broken frames, with random
// gaps on the byte side and random stalls on the result side.
// ----------------------------------------------------------------------------
module stx_etx_frame_extractor_core_tb;
  import stxetx_pkg::*;

  localparam int FRAME_DEPTH   = 64;
  localparam int ITEM_TARGET   = 410;
  localparam int NUM_PHASES    = 5;
  localparam int SETTLE_CYCLES = FRAME_DEPTH + 16;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BYTE_W-1:0]    cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [BYTE_W-1:0]    in_rx_byte;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [BYTE_W-1:0]    out_payload_byte;
  logic                 out_frame_last;
  logic                 out_frame_empty;
  logic                 out_frame_overflow;
  int                   fail_count;
  int                   words_due;

  logic [BYTE_W-1:0]    cur_stx = START_MARKER_RST;
  logic [BYTE_W-1:0]    cur_etx = END_MARKER_RST;
  logic                 no_gaps = 1'b0;
  int                   items = 0;
  int unsigned          hold_left = 0;
  int unsigned          stall_pick;

  stx_etx_frame_extractor_core #(
    .FRAME_DEPTH(FRAME_DEPTH)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_payload_byte  (out_payload_byte),
    .out_frame_last    (out_frame_last),
    .out_frame_empty   (out_frame_empty),
    .out_frame_overflow(out_frame_overflow)
  );

  stx_etx_frame_monitor #(
    .FRAME_DEPTH(FRAME_DEPTH)
  ) i_monitor (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_payload_byte  (out_payload_byte),
    .out_frame_last    (out_frame_last),
    .out_frame_empty   (out_frame_empty),
    .out_frame_overflow(out_frame_overflow),
    .fail_count        (fail_count),
    .words_due         (words_due)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 40) begin
        out_stall <= 1'b0;
        hold_left <= $urandom_range(5, 60);
      end else if (stall_pick < 88) begin
        out_stall <= 1'($urandom_range(0, 1));
        hold_left <= $urandom_range(0, 3);
      end else begin
        out_stall <= 1'b1;
        hold_left <= $urandom_range(8, 40);
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) begin
      return 0;
    end else if (p < 85) begin
      return $urandom_range(1, 3);
    end else if (p < 96) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [BYTE_W-1:0] plain_byte();
    logic [BYTE_W-1:0] b;
    do begin
      b = BYTE_W'($urandom_range(0, 255));
    end while (b == cur_stx || b == cur_etx);
    return b;
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int unsigned gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_frame(input int len, input logic restart);
    int k;
    send_byte(cur_stx);
    items++;
    if (restart && cur_stx != cur_etx) begin
      repeat ($urandom_range(1, 4)) begin
        send_byte(plain_byte());
        items++;
      end
      send_byte(cur_stx);
      items++;
    end
    for (k = 0; k < len; k++) begin
      send_byte(plain_byte());
      items++;
    end
    send_byte(cur_etx);
    items++;
  endtask

  task automatic write_markers(input logic [BYTE_W-1:0] stx, input logic [BYTE_W-1:0] etx);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_START_MARKER;
    cfg_data  <= stx;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_END_MARKER;
    cfg_data  <= etx;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_stx = stx;
    cur_etx = etx;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(input int goal);
    int unsigned p;
    int          len;
    int          k;
    while (items < goal) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      p = $urandom_range(0, 99);
      if (p < 75) begin
        repeat ($urandom_range(0, 2)) begin
          send_byte(plain_byte());
          items++;
        end
        p = $urandom_range(0, 99);
        if (p < 8) begin
          len = 0;
        end else if (p < 70) begin
          len = $urandom_range(1, 8);
        end else if (p < 88) begin
          len = $urandom_range(9, 40);
        end else if (p < 94) begin
          len = $urandom_range(41, FRAME_DEPTH - 1);
        end else if (p < 97) begin
          len = FRAME_DEPTH;
        end else begin
          len = $urandom_range(FRAME_DEPTH + 1, FRAME_DEPTH + 6);
        end
        send_frame(len, ($urandom_range(0, 6) == 0));
      end else if (p < 88) begin
        repeat ($urandom_range(1, 6)) begin
          send_byte(BYTE_W'($urandom_range(0, 255)));
          items++;
        end
      end else begin
        send_byte(cur_stx);
        items++;
        len = $urandom_range(0, 5);
        for (k = 0; k < len; k++) begin
          send_byte(BYTE_W'($urandom_range(0, 255)));
          items++;
        end
      end
    end
    send_byte(cur_etx);
    items++;
  endtask

  initial begin
    int                ph;
    logic [BYTE_W-1:0] stx;
    logic [BYTE_W-1:0] etx;
    rst_n      = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_START_MARKER;
    cfg_data   = '0;
    in_valid   = 1'b0;
    in_rx_byte = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset markers: noise, data frame, empty frame, restarted frame, data frame
    send_byte(END_MARKER_RST);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(START_MARKER_RST);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h55);
    send_byte(8'hAA);
    send_byte(END_MARKER_RST);
    send_byte(START_MARKER_RST);
    send_byte(END_MARKER_RST);
    send_byte(START_MARKER_RST);
    send_byte(8'h11);
    send_byte(8'h22);
    send_byte(START_MARKER_RST);
    send_byte(8'h33);
    send_byte(END_MARKER_RST);
    send_byte(START_MARKER_RST);
    send_byte(8'h01);
    send_byte(8'h80);
    send_byte(8'h7F);
    send_byte(8'hFE);
    send_byte(END_MARKER_RST);
    items = 23;
    settle();

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin
          stx = 8'h00;
          etx = 8'hFF;
        end
        1: begin
          stx = 8'hFF;
          etx = 8'h00;
        end
        2: begin
          stx = 8'h7E;
          etx = 8'h7E;
        end
        3: begin
          stx = BYTE_W'($urandom_range(0, 255));
          etx = BYTE_W'($urandom_range(0, 255));
        end
        default: begin
          stx = START_MARKER_RST;
          etx = END_MARKER_RST;
        end
      endcase
      write_markers(stx, etx);
      if (ph < 2) begin
        send_frame(FRAME_DEPTH + ph, 1'b0);
      end
      random_phase(items + (ITEM_TARGET - items) / (NUM_PHASES - ph));
      settle();
    end

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/stxetx_pkg.sv
hdl/stxetx_ram.sv
hdl/stxetx_queue.sv
hdl/stxetx_front.sv
hdl/stxetx_back.sv
hdl/stx_etx_frame_extractor_core.sv
sim/stx_etx_frame_monitor.sv
sim/stx_etx_frame_extractor_core_tb.sv
